>>> src/fali_pkg.sv
// ----------------------------------------------------------------------------
// fali_pkg - shared definitions for the fixed array list insert core
// Action codes, walk unit command/status types and default sizes.
// ----------------------------------------------------------------------------
package fali_pkg;

    localparam int FALI_CAPACITY     = 64;
    localparam int FALI_PAYLOAD_BITS = 32;

    localparam int KEY_W      = 32;
    localparam int PAY_PORT_W = 32;
    localparam int IDX_W      = 6;
    localparam int CNT_PORT_W = 7;

    localparam logic [1:0] ACT_APPEND  = 2'd0;
    localparam logic [1:0] ACT_PREPEND = 2'd1;
    localparam logic [1:0] ACT_INSERT  = 2'd2;
    localparam logic [1:0] ACT_READ    = 2'd3;

    typedef enum logic [1:0] {
        WALK_HOLD,
        WALK_LOAD,
        WALK_INC,
        WALK_DEC
    } walk_op_t;

    typedef struct packed {
        walk_op_t op;
    } walk_cmd_t;

    typedef struct packed {
        logic at_limit;
        logic key_lt;
    } walk_stat_t;

endpackage

>>> src/fali_store.sv
// ----------------------------------------------------------------------------
// fali_store - entry memory
// Key and payload arrays, one write port, one read port with registered data.
// ----------------------------------------------------------------------------
module fali_store
    import fali_pkg::*;
#(
    parameter int CAPACITY     = FALI_CAPACITY,
    parameter int PAYLOAD_BITS = FALI_PAYLOAD_BITS
)
(
    input  logic                           clk,
    input  logic                           wr_en,
    input  logic [$clog2(CAPACITY)-1:0]    wr_addr,
    input  logic signed [KEY_W-1:0]        wr_key,
    input  logic [PAYLOAD_BITS-1:0]        wr_payload,
    input  logic                           rd_en,
    input  logic [$clog2(CAPACITY)-1:0]    rd_addr,
    output logic signed [KEY_W-1:0]        rd_key,
    output logic [PAYLOAD_BITS-1:0]        rd_payload
);

    logic signed [KEY_W-1:0]   key_mem [CAPACITY];
    logic [PAYLOAD_BITS-1:0]   pay_mem [CAPACITY];

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            key_mem[wr_addr] <= wr_key;
            pay_mem[wr_addr] <= wr_payload;
        end
    end

    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            rd_key     <= key_mem[rd_addr];
            rd_payload <= pay_mem[rd_addr];
        end
    end

endmodule

>>> src/fali_walk.sv
// ----------------------------------------------------------------------------
// fali_walk - shared walk unit
// Position pointer with load/step, limit compare and signed key compare.
// ----------------------------------------------------------------------------
module fali_walk
    import fali_pkg::*;
#(
    parameter int CAPACITY = FALI_CAPACITY
)
(
    input  logic                           clk,
    input  logic                           rst_n,
    input  walk_cmd_t                      cmd,
    input  logic [$clog2(CAPACITY)-1:0]    load_val,
    input  logic [$clog2(CAPACITY)-1:0]    limit,
    input  logic signed [KEY_W-1:0]        key_a,
    input  logic signed [KEY_W-1:0]        key_b,
    output logic [$clog2(CAPACITY)-1:0]    ptr,
    output logic [$clog2(CAPACITY)-1:0]    ptr_prev,
    output walk_stat_t                     stat
);

    localparam int AW = $clog2(CAPACITY);

    logic [AW-1:0] ptr_reg;
    logic [AW-1:0] ptr_next;

    always_comb
    begin
        ptr_next = ptr_reg;
        unique case (cmd.op)
            WALK_HOLD: ptr_next = ptr_reg;
            WALK_LOAD: ptr_next = load_val;
            WALK_INC:  ptr_next = ptr_reg + 1'b1;
            WALK_DEC:  ptr_next = ptr_reg - 1'b1;
            default:   ptr_next = ptr_reg;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            ptr_reg <= '0;
        else
            ptr_reg <= ptr_next;
    end

    assign ptr           = ptr_reg;
    assign ptr_prev      = ptr_reg - 1'b1;
    assign stat.at_limit = (ptr_reg == limit);
    assign stat.key_lt   = (key_a < key_b);

endmodule

>>> src/fixed_array_list_insert_core.sv
// ----------------------------------------------------------------------------
// fixed_array_list_insert_core - fixed capacity list with ordered insert
// Stores signed-key records; append, prepend, ordered insert and read.
// ----------------------------------------------------------------------------
// Usage:
//   A transaction is taken when start is high and busy is low; action,
//   entry_key, entry_payload and read_index are sampled on that edge.
//   Each transaction yields exactly one result, shown for one cycle with
//   done high; the receiver cannot stall, so it must take it then.
// Work per transaction, n = stored entries:
//   read, append, rejected : no walk over the entries
//   prepend                : all n entries moved up one place
//   ordered insert         : s entries passed over in the search,
//                            m entries moved up (s + m = n); nothing
//                            is moved when the new key goes last
// Every entry visited goes through the single memory read port:
// address out, registered data back, then compare or write one place up.
// One walk pointer and comparator serve both the search and the move pass.
// Busy is high until the result, never for rejects; one transaction at a time.
// Reset empties the list (count zero); the memory is not cleared, as an
// entry is only ever read after it has been written.
// ----------------------------------------------------------------------------
module fixed_array_list_insert_core
    import fali_pkg::*;
#(
    parameter int CAPACITY     = FALI_CAPACITY,
    parameter int PAYLOAD_BITS = FALI_PAYLOAD_BITS
)
(
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         start,
    output logic                         busy,
    input  logic [1:0]                   action,
    input  logic signed [KEY_W-1:0]      entry_key,
    input  logic [PAY_PORT_W-1:0]        entry_payload,
    input  logic [IDX_W-1:0]             read_index,
    output logic                         done,
    output logic                         accepted,
    output logic [CNT_PORT_W-1:0]        item_count,
    output logic                         is_full,
    output logic                         is_empty,
    output logic signed [KEY_W-1:0]      out_key,
    output logic [PAY_PORT_W-1:0]        out_payload
);

    localparam int AW = $clog2(CAPACITY);
    localparam int CW = $clog2(CAPACITY + 1);

    typedef enum logic [2:0] {
        S_IDLE,
        S_READ,
        S_SEARCH,
        S_CMP,
        S_SHIFT,
        S_MOVE,
        S_WRITE
    } state_t;

    state_t                   state_reg, state_next;
    logic [CW-1:0]            count_reg, count_next;
    logic [1:0]               act_reg, act_next;
    logic signed [KEY_W-1:0]  key_reg, key_next;
    logic [PAYLOAD_BITS-1:0]  pay_reg, pay_next;
    logic [AW-1:0]            pos_reg, pos_next;

    // result registers
    logic                     done_reg, done_next;
    logic                     acc_reg, acc_next;
    logic [CNT_PORT_W-1:0]    cnt_out_reg, cnt_out_next;
    logic                     full_reg, full_next;
    logic                     empty_reg, empty_next;
    logic signed [KEY_W-1:0]  okey_reg, okey_next;
    logic [PAY_PORT_W-1:0]    opay_reg, opay_next;

    // memory port
    logic                     wr_en;
    logic [AW-1:0]            wr_addr;
    logic signed [KEY_W-1:0]  wr_key;
    logic [PAYLOAD_BITS-1:0]  wr_payload;
    logic                     rd_en;
    logic [AW-1:0]            rd_addr;
    logic signed [KEY_W-1:0]  rd_key;
    logic [PAYLOAD_BITS-1:0]  rd_payload;

    // walk unit
    walk_cmd_t                walk_cmd;
    walk_stat_t               walk_stat;
    logic [AW-1:0]            walk_load;
    logic [AW-1:0]            walk_limit;
    logic [AW-1:0]            walk_ptr;
    logic [AW-1:0]            walk_prev;

    logic                     is_full_now;
    logic                     ridx_ok;

    fali_store #(
        .CAPACITY     (CAPACITY),
        .PAYLOAD_BITS (PAYLOAD_BITS)
    ) u_store (
        .clk        (clk),
        .wr_en      (wr_en),
        .wr_addr    (wr_addr),
        .wr_key     (wr_key),
        .wr_payload (wr_payload),
        .rd_en      (rd_en),
        .rd_addr    (rd_addr),
        .rd_key     (rd_key),
        .rd_payload (rd_payload)
    );

    fali_walk #(
        .CAPACITY (CAPACITY)
    ) u_walk (
        .clk      (clk),
        .rst_n    (rst_n),
        .cmd      (walk_cmd),
        .load_val (walk_load),
        .limit    (walk_limit),
        .key_a    (rd_key),
        .key_b    (key_reg),
        .ptr      (walk_ptr),
        .ptr_prev (walk_prev),
        .stat     (walk_stat)
    );

    assign is_full_now = (count_reg == CW'(CAPACITY));
    assign ridx_ok     = (32'(read_index) < 32'(count_reg));

    // search stops at the count, the move pass at the insert position
    assign walk_limit  = (state_reg == S_SHIFT) ? pos_reg : AW'(count_reg);

    always_comb
    begin
        state_next   = state_reg;
        count_next   = count_reg;
        act_next     = act_reg;
        key_next     = key_reg;
        pay_next     = pay_reg;
        pos_next     = pos_reg;
        done_next    = 1'b0;
        acc_next     = acc_reg;
        cnt_out_next = cnt_out_reg;
        full_next    = full_reg;
        empty_next   = empty_reg;
        okey_next    = okey_reg;
        opay_next    = opay_reg;
        wr_en        = 1'b0;
        wr_addr      = pos_reg;
        wr_key       = key_reg;
        wr_payload   = pay_reg;
        rd_en        = 1'b0;
        rd_addr      = walk_ptr;
        walk_cmd.op  = WALK_HOLD;
        walk_load    = AW'(count_reg);

        unique case (state_reg)
            S_IDLE:
            begin
                if (start)
                begin
                    act_next = action;
                    key_next = entry_key;
                    pay_next = PAYLOAD_BITS'(entry_payload);
                    if (action == ACT_READ)
                    begin
                        if (ridx_ok)
                        begin
                            rd_en      = 1'b1;
                            rd_addr    = AW'(read_index);
                            state_next = S_READ;
                        end
                        else
                        begin
                            done_next = 1'b1;
                            acc_next  = 1'b0;
                            okey_next = '0;
                            opay_next = '0;
                        end
                    end
                    else if (is_full_now)
                    begin
                        done_next = 1'b1;
                        acc_next  = 1'b0;
                        okey_next = '0;
                        opay_next = '0;
                    end
                    else
                    begin
                        unique case (action)
                            ACT_APPEND:
                            begin
                                pos_next   = AW'(count_reg);
                                state_next = S_WRITE;
                            end
                            ACT_PREPEND:
                            begin
                                pos_next    = '0;
                                walk_cmd.op = WALK_LOAD;
                                walk_load   = AW'(count_reg);
                                state_next  = S_SHIFT;
                            end
                            default:
                            begin
                                walk_cmd.op = WALK_LOAD;
                                walk_load   = '0;
                                state_next  = S_SEARCH;
                            end
                        endcase
                    end
                end
            end

            S_READ:
            begin
                done_next  = 1'b1;
                acc_next   = 1'b1;
                okey_next  = rd_key;
                opay_next  = PAY_PORT_W'(rd_payload);
                state_next = S_IDLE;
            end

            S_SEARCH:
            begin
                if (walk_stat.at_limit)
                begin
                    // every entry is less: goes at the end, nothing to move
                    pos_next   = walk_ptr;
                    state_next = S_SHIFT;
                end
                else
                begin
                    rd_en      = 1'b1;
                    rd_addr    = walk_ptr;
                    state_next = S_CMP;
                end
            end

            S_CMP:
            begin
                if (walk_stat.key_lt)
                begin
                    walk_cmd.op = WALK_INC;
                    state_next  = S_SEARCH;
                end
                else
                begin
                    pos_next    = walk_ptr;
                    walk_cmd.op = WALK_LOAD;
                    walk_load   = AW'(count_reg);
                    state_next  = S_SHIFT;
                end
            end

            S_SHIFT:
            begin
                if (walk_stat.at_limit)
                    state_next = S_WRITE;
                else
                begin
                    rd_en      = 1'b1;
                    rd_addr    = walk_prev;
                    state_next = S_MOVE;
                end
            end

            S_MOVE:
            begin
                wr_en       = 1'b1;
                wr_addr     = walk_ptr;
                wr_key      = rd_key;
                wr_payload  = rd_payload;
                walk_cmd.op = WALK_DEC;
                state_next  = S_SHIFT;
            end

            S_WRITE:
            begin
                wr_en      = 1'b1;
                wr_addr    = pos_reg;
                count_next = count_reg + 1'b1;
                done_next  = 1'b1;
                acc_next   = 1'b1;
                okey_next  = '0;
                opay_next  = '0;
                state_next = S_IDLE;
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase

        if (done_next)
        begin
            cnt_out_next = CNT_PORT_W'(count_next);
            full_next    = (count_next == CW'(CAPACITY));
            empty_next   = (count_next == '0);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= S_IDLE;
            count_reg   <= '0;
            done_reg    <= 1'b0;
            acc_reg     <= 1'b0;
            cnt_out_reg <= '0;
            full_reg    <= 1'b0;
            empty_reg   <= 1'b1;
            okey_reg    <= '0;
            opay_reg    <= '0;
        end
        else
        begin
            state_reg   <= state_next;
            count_reg   <= count_next;
            done_reg    <= done_next;
            acc_reg     <= acc_next;
            cnt_out_reg <= cnt_out_next;
            full_reg    <= full_next;
            empty_reg   <= empty_next;
            okey_reg    <= okey_next;
            opay_reg    <= opay_next;
        end
    end

    // transaction payload, no reset needed
    always_ff @(posedge clk)
    begin
        act_reg <= act_next;
        key_reg <= key_next;
        pay_reg <= pay_next;
        pos_reg <= pos_next;
    end

    assign busy        = (state_reg != S_IDLE);
    assign done        = done_reg;
    assign accepted    = acc_reg;
    assign item_count  = cnt_out_reg;
    assign is_full     = full_reg;
    assign is_empty    = empty_reg;
    assign out_key     = okey_reg;
    assign out_payload = opay_reg;

    // ------------------------------------------------------------------------
    // assertions
    // ------------------------------------------------------------------------
    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CW'(CAPACITY))
        else $error("stored count beyond capacity");

    a_done_idle: assert property (@(posedge clk) disable iff (!rst_n)
        done_reg |-> (state_reg == S_IDLE))
        else $error("result strobe while a transaction is still running");

    a_write_in_range: assert property (@(posedge clk) disable iff (!rst_n)
        wr_en |-> (CW'(wr_addr) <= count_reg))
        else $error("memory write beyond the end of the list");

    a_store_counts: assert property (@(posedge clk) disable iff (!rst_n)
        (done_reg && acc_reg && (act_reg != ACT_READ))
            |-> (count_reg == $past(count_reg) + 1'b1))
        else $error("accepted store did not grow the list by one");

endmodule
